FILE: hw/rtl/lfsp_pkg.sv
// ----------------------------------------------------------------------------
// lfsp_pkg: shared types and constants of the line follower steering block
// Register map, reset values and the packed set of speed and gain settings
// that travel from the register file to the steering datapath.
// ----------------------------------------------------------------------------
package lfsp_pkg;

    // Field widths that the motor interface and the gain format fix.
    localparam int SPEED_W = 8;
    localparam int GAIN_W  = 16;
    localparam int POS_W   = 4;

    // APB register port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // Register indexes (byte address is four times the index).
    localparam logic [IDX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_STRAIGHT_SPEED = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLIGHT_SPEED   = 3'd2;
    localparam logic [IDX_W-1:0] REG_PD_BASE_SPEED  = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN_PROP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAIN_DERIV     = 3'd5;

    // Values after reset.
    localparam int                 LINE_THRESHOLD_RST = 120;
    localparam logic [SPEED_W-1:0] STRAIGHT_SPEED_RST = 8'd72;
    localparam logic [SPEED_W-1:0] SLIGHT_SPEED_RST   = 8'd70;
    localparam logic [SPEED_W-1:0] PD_BASE_SPEED_RST  = 8'd55;
    localparam logic [GAIN_W-1:0]  GAIN_PROP_RST      = 16'd2240;
    localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST     = 16'd371;

    // Speed and gain settings seen by the datapath.
    typedef struct packed {
        logic [SPEED_W-1:0] straight_speed;
        logic [SPEED_W-1:0] slight_speed;
        logic [SPEED_W-1:0] pd_base_speed;
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_deriv;
    } steer_cfg_t;

endpackage

FILE: hw/rtl/line_follower_steering_pd.sv
// ----------------------------------------------------------------------------
// line_follower_steering_pd: line position decode and motor steering
// Turns one sample of six line sensors into a decoded line position and a
// pair of saturated motor speed commands, by bang-bang or PD control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one sample of six sensor
//   readings (leftmost first). A transfer happens at a rising edge with
//   in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry one result per sample:
//   line_position, mode_bang, speed_a, speed_b and speeds_valid.
//   Configuration goes through the APB port (byte address 4 * index). The user
//   must change it only while no sample is in flight; the block does not enforce this.
//   A sample passes the input register, then decode, multiply and saturate
//   into the result register, which drives out_valid.
//   Throughput is one sample per cycle; both stages advance together as long
//   as the result register is empty or being taken.
//   When the receiver stalls, the result holds and the input register still
//   takes one more sample; after that in_stall rises until the result moves.
//   Reset empties both stages, clears the stored last error to zero and
//   loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module line_follower_steering_pd #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfsp_pkg::ADDR_W-1:0] paddr,
    input  logic [lfsp_pkg::DATA_W-1:0] pwdata,
    output logic [lfsp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // sample channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [SAMPLE_BITS-1:0]      sensor_one,
    input  logic [SAMPLE_BITS-1:0]      sensor_two,
    input  logic [SAMPLE_BITS-1:0]      sensor_three,
    input  logic [SAMPLE_BITS-1:0]      sensor_four,
    input  logic [SAMPLE_BITS-1:0]      sensor_five,
    input  logic [SAMPLE_BITS-1:0]      sensor_six,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [lfsp_pkg::POS_W-1:0]   line_position,
    output logic                        mode_bang,
    output logic [lfsp_pkg::SPEED_W-1:0] speed_a,
    output logic [lfsp_pkg::SPEED_W-1:0] speed_b,
    output logic                        speeds_valid
);
    import lfsp_pkg::*;

    localparam int NUM_SENSORS = 6;
    localparam int PROD_W      = 22;  // holds gain * error sums with sign
    localparam int CTRL_W      = 14;  // control term and base +/- control

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] line_threshold;
    steer_cfg_t             cfg;

    lfsp_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .line_threshold (line_threshold),
        .cfg            (cfg)
    );

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic in_take;
    logic advance;

    logic [SAMPLE_BITS-1:0] sample_reg [NUM_SENSORS];

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input register: valid bit and captured sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg[0] <= sensor_one;
            sample_reg[1] <= sensor_two;
            sample_reg[2] <= sensor_three;
            sample_reg[3] <= sensor_four;
            sample_reg[4] <= sensor_five;
            sample_reg[5] <= sensor_six;
        end
    end

    // ------------------------------------------------------------------
    // Threshold compare and position decode
    // ------------------------------------------------------------------
    logic [NUM_SENSORS-1:0] seen;
    logic signed [POS_W-1:0] pos;
    logic                    bang;

    always_comb
    begin
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            seen[i] = sample_reg[i] < line_threshold;
        end
    end

    // Only a single sensor or two neighbors give a position off center.
    always_comb
    begin
        case (seen)
            6'b000001: pos = -4'sd5;
            6'b000011: pos = -4'sd4;
            6'b000010: pos = -4'sd3;
            6'b000110: pos = -4'sd2;
            6'b000100: pos = -4'sd1;
            6'b001000: pos =  4'sd1;
            6'b011000: pos =  4'sd2;
            6'b010000: pos =  4'sd3;
            6'b110000: pos =  4'sd4;
            6'b100000: pos =  4'sd5;
            default:   pos =  4'sd0;
        endcase
    end

    assign bang = (pos == -4'sd1) || (pos == 4'sd0) || (pos == 4'sd1);

    // ------------------------------------------------------------------
    // PD control term
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]  prev_error_reg;
    logic signed [POS_W-1:0]  err;
    logic signed [POS_W:0]    deriv;
    logic signed [PROD_W-1:0] gp_s;
    logic signed [PROD_W-1:0] gd_s;
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] sum_adj;
    logic signed [PROD_W-1:0] sum_shr;
    logic signed [CTRL_W-1:0] ctrl;
    logic signed [CTRL_W-1:0] base_s;
    logic signed [CTRL_W-1:0] raw_a;
    logic signed [CTRL_W-1:0] raw_b;
    logic [SPEED_W-1:0]       pd_a;
    logic [SPEED_W-1:0]       pd_b;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [CTRL_W-1:0] v);
        logic [SPEED_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > CTRL_W'(signed'(255)))
            r = '1;
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        err     = -pos;
        deriv   = (POS_W+1)'(err) - (POS_W+1)'(prev_error_reg);
        gp_s    = signed'(PROD_W'(cfg.gain_prop));
        gd_s    = signed'(PROD_W'(cfg.gain_deriv));
        sum     = gp_s * PROD_W'(err) + gd_s * PROD_W'(deriv);
        // Bias negative sums so the shift truncates toward zero.
        sum_adj = (sum < 0) ? sum + PROD_W'(signed'(255)) : sum;
        sum_shr = sum_adj >>> 8;
        ctrl    = sum_shr[CTRL_W-1:0];
        base_s  = signed'(CTRL_W'(cfg.pd_base_speed));
        raw_a   = base_s + ctrl;
        raw_b   = base_s - ctrl;
        pd_a    = sat_speed(raw_a);
        pd_b    = sat_speed(raw_b);
    end

    // ------------------------------------------------------------------
    // Speed selection
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] sel_a;
    logic [SPEED_W-1:0] sel_b;
    logic               sel_valid;

    always_comb
    begin
        sel_a     = '0;
        sel_b     = '0;
        sel_valid = 1'b0;
        if (!bang)
        begin
            sel_a     = pd_a;
            sel_b     = pd_b;
            sel_valid = 1'b1;
        end
        else if (seen[2] && seen[3])
        begin
            sel_a     = cfg.straight_speed;
            sel_b     = cfg.straight_speed;
            sel_valid = 1'b1;
        end
        else if (seen[3])
        begin
            sel_a     = cfg.straight_speed;
            sel_b     = cfg.slight_speed;
            sel_valid = 1'b1;
        end
        else if (seen[2])
        begin
            sel_a     = cfg.slight_speed;
            sel_b     = cfg.straight_speed;
            sel_valid = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result register and stored last error
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] position_reg;
    logic                    mode_bang_reg;
    logic [SPEED_W-1:0]      speed_a_reg;
    logic [SPEED_W-1:0]      speed_b_reg;
    logic                    speeds_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && !bang)
            begin
                prev_error_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            position_reg     <= pos;
            mode_bang_reg    <= bang;
            speed_a_reg      <= sel_a;
            speed_b_reg      <= sel_b;
            speeds_valid_reg <= sel_valid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_position = position_reg;
    assign mode_bang     = mode_bang_reg;
    assign speed_a       = speed_a_reg;
    assign speed_b       = speed_b_reg;
    assign speeds_valid  = speeds_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A PD result always updates the speeds.
    a_pd_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !mode_bang_reg) |-> speeds_valid_reg)
        else $error("PD result without speed update");

    // PD mode only runs off the center band.
    a_pd_off_center: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !mode_bang_reg) |->
            (position_reg != 4'sd0) && (position_reg != 4'sd1) && (position_reg != -4'sd1))
        else $error("PD result inside the center band");

    // A bang-bang sample without sensor three or four reports zero speeds.
    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !speeds_valid_reg) |->
            (speed_a_reg == '0) && (speed_b_reg == '0))
        else $error("speeds not zero without update");

    // While a PD result waits, the stored error is that result's error.
    a_prev_error_track: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !mode_bang_reg) |-> (prev_error_reg == -position_reg))
        else $error("stored last error out of step with the result");

    // The input stage never drops a sample while the result is stalled.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |=> in_valid_reg)
        else $error("input stage lost a sample under stall");

endmodule

FILE: hw/rtl/lfsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfsp_cfg_regs: APB configuration registers
// Holds the line threshold, the bang-bang and PD speeds and the two Q8.8
// gains. Writes complete in the access cycle; reads return the stored value.
// ----------------------------------------------------------------------------
module lfsp_cfg_regs #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lfsp_pkg::ADDR_W-1:0] paddr,
    input  logic [lfsp_pkg::DATA_W-1:0] pwdata,
    output logic [lfsp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [SAMPLE_BITS-1:0]     line_threshold,
    output lfsp_pkg::steer_cfg_t       cfg
);
    import lfsp_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(LINE_THRESHOLD_RST);

    logic [SAMPLE_BITS-1:0] threshold_reg;
    steer_cfg_t             cfg_reg;
    logic [IDX_W-1:0]       reg_idx;
    logic                   wr_en;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg          <= THRESHOLD_RST;
            cfg_reg.straight_speed <= STRAIGHT_SPEED_RST;
            cfg_reg.slight_speed   <= SLIGHT_SPEED_RST;
            cfg_reg.pd_base_speed  <= PD_BASE_SPEED_RST;
            cfg_reg.gain_prop      <= GAIN_PROP_RST;
            cfg_reg.gain_deriv     <= GAIN_DERIV_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LINE_THRESHOLD: threshold_reg          <= pwdata[SAMPLE_BITS-1:0];
                REG_STRAIGHT_SPEED: cfg_reg.straight_speed <= pwdata[SPEED_W-1:0];
                REG_SLIGHT_SPEED:   cfg_reg.slight_speed   <= pwdata[SPEED_W-1:0];
                REG_PD_BASE_SPEED:  cfg_reg.pd_base_speed  <= pwdata[SPEED_W-1:0];
                REG_GAIN_PROP:      cfg_reg.gain_prop      <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:     cfg_reg.gain_deriv     <= pwdata[GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read mux; unused addresses read as zero.
    always_comb
    begin
        case (reg_idx)
            REG_LINE_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_STRAIGHT_SPEED: prdata = DATA_W'(cfg_reg.straight_speed);
            REG_SLIGHT_SPEED:   prdata = DATA_W'(cfg_reg.slight_speed);
            REG_PD_BASE_SPEED:  prdata = DATA_W'(cfg_reg.pd_base_speed);
            REG_GAIN_PROP:      prdata = DATA_W'(cfg_reg.gain_prop);
            REG_GAIN_DERIV:     prdata = DATA_W'(cfg_reg.gain_deriv);
            default:            prdata = '0;
        endcase
    end

    assign line_threshold = threshold_reg;
    assign cfg            = cfg_reg;

endmodule

FILE: bench/steering_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steering_checker: result predictor and comparator for the steering block
// Watches the register port, the sample channel and the result channel. It
// keeps its own copy of the settings and of the last PD error, predicts one
// result per sample transfer and compares each result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module steering_checker #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [lfsp_pkg::ADDR_W-1:0]         paddr,
    input  logic [lfsp_pkg::DATA_W-1:0]         pwdata,
    // sample channel
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              sensor_one,
    input  logic [SAMPLE_BITS-1:0]              sensor_two,
    input  logic [SAMPLE_BITS-1:0]              sensor_three,
    input  logic [SAMPLE_BITS-1:0]              sensor_four,
    input  logic [SAMPLE_BITS-1:0]              sensor_five,
    input  logic [SAMPLE_BITS-1:0]              sensor_six,
    // result channel
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [lfsp_pkg::POS_W-1:0]   line_position,
    input  logic                                mode_bang,
    input  logic [lfsp_pkg::SPEED_W-1:0]        speed_a,
    input  logic [lfsp_pkg::SPEED_W-1:0]        speed_b,
    input  logic                                speeds_valid,
    // status toward the testbench top
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import lfsp_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0] line_position;
        logic                    mode_bang;
        logic [SPEED_W-1:0]      speed_a;
        logic [SPEED_W-1:0]      speed_b;
        logic                    speeds_valid;
    } steer_result_t;

    // Shadow copy of the settings and of the stored PD error.
    logic [SAMPLE_BITS-1:0]  thr_q;
    logic [SPEED_W-1:0]      straight_q;
    logic [SPEED_W-1:0]      slight_q;
    logic [SPEED_W-1:0]      base_q;
    logic [GAIN_W-1:0]       kp_q;
    logic [GAIN_W-1:0]       kd_q;
    logic signed [POS_W-1:0] pd_error_q;

    steer_result_t expected_steering [$];
    int            errors = 0;

    task automatic report_mismatch(input string msg);
        $display("steering_checker: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [SPEED_W-1:0] clamp_speed(input longint v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return v[SPEED_W-1:0];
    endfunction

    // Decode the seen pattern and work out the steering command for one sample.
    function automatic steer_result_t predict_steering(
        input logic [SAMPLE_BITS-1:0] r1,
        input logic [SAMPLE_BITS-1:0] r2,
        input logic [SAMPLE_BITS-1:0] r3,
        input logic [SAMPLE_BITS-1:0] r4,
        input logic [SAMPLE_BITS-1:0] r5,
        input logic [SAMPLE_BITS-1:0] r6
    );
        logic [5:0]    seen;
        int            pos;
        int            err;
        int            deriv;
        longint        sum;
        longint        ctrl;
        steer_result_t res;
        seen = {r6 < thr_q, r5 < thr_q, r4 < thr_q, r3 < thr_q, r2 < thr_q, r1 < thr_q};
        case (seen)
            6'b000001: pos = -5;
            6'b000011: pos = -4;
            6'b000010: pos = -3;
            6'b000110: pos = -2;
            6'b000100: pos = -1;
            6'b001000: pos = 1;
            6'b011000: pos = 2;
            6'b010000: pos = 3;
            6'b110000: pos = 4;
            6'b100000: pos = 5;
            default:   pos = 0;
        endcase
        res.line_position = pos[POS_W-1:0];
        res.mode_bang     = (pos >= -1 && pos <= 1);
        res.speed_a       = '0;
        res.speed_b       = '0;
        res.speeds_valid  = 1'b0;
        if (res.mode_bang)
        begin
            // Center band: fixed speeds from sensors three and four.
            if (seen[2] && seen[3])
            begin
                res.speed_a = straight_q;
                res.speed_b = straight_q;
                res.speeds_valid = 1'b1;
            end
            else if (seen[3])
            begin
                res.speed_a = straight_q;
                res.speed_b = slight_q;
                res.speeds_valid = 1'b1;
            end
            else if (seen[2])
            begin
                res.speed_a = slight_q;
                res.speed_b = straight_q;
                res.speeds_valid = 1'b1;
            end
        end
        else
        begin
            // PD law; the division truncates toward zero.
            err   = -pos;
            deriv = err - int'(pd_error_q);
            sum   = longint'(kp_q) * err + longint'(kd_q) * deriv;
            ctrl  = sum / 256;
            res.speed_a = clamp_speed(longint'(base_q) + ctrl);
            res.speed_b = clamp_speed(longint'(base_q) - ctrl);
            res.speeds_valid = 1'b1;
            pd_error_q = err[POS_W-1:0];
        end
        return res;
    endfunction

    task automatic check_result(input steer_result_t exp);
        if (line_position !== exp.line_position)
            report_mismatch($sformatf("line_position got %0d expected %0d",
                                      line_position, exp.line_position));
        if (mode_bang !== exp.mode_bang)
            report_mismatch($sformatf("mode_bang got %b expected %b", mode_bang, exp.mode_bang));
        if (speed_a !== exp.speed_a)
            report_mismatch($sformatf("speed_a got %0d expected %0d", speed_a, exp.speed_a));
        if (speed_b !== exp.speed_b)
            report_mismatch($sformatf("speed_b got %0d expected %0d", speed_b, exp.speed_b));
        if (speeds_valid !== exp.speeds_valid)
            report_mismatch($sformatf("speeds_valid got %b expected %b",
                                      speeds_valid, exp.speeds_valid));
    endtask

    // Results are taken before new samples so that a result never meets the
    // prediction of a sample that transfers at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_q      = SAMPLE_BITS'(LINE_THRESHOLD_RST);
            straight_q = STRAIGHT_SPEED_RST;
            slight_q   = SLIGHT_SPEED_RST;
            base_q     = PD_BASE_SPEED_RST;
            kp_q       = GAIN_PROP_RST;
            kd_q       = GAIN_DERIV_RST;
            pd_error_q = '0;
            expected_steering.delete();
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_steering.size() == 0)
                    report_mismatch("result transfer with no sample waiting");
                else
                    check_result(expected_steering.pop_front());
            end
            if (in_valid && !in_stall)
                expected_steering.push_back(predict_steering(sensor_one, sensor_two,
                    sensor_three, sensor_four, sensor_five, sensor_six));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[IDX_W+1:2])
                    REG_LINE_THRESHOLD: thr_q      = pwdata[SAMPLE_BITS-1:0];
                    REG_STRAIGHT_SPEED: straight_q = pwdata[SPEED_W-1:0];
                    REG_SLIGHT_SPEED:   slight_q   = pwdata[SPEED_W-1:0];
                    REG_PD_BASE_SPEED:  base_q     = pwdata[SPEED_W-1:0];
                    REG_GAIN_PROP:      kp_q       = pwdata[GAIN_W-1:0];
                    REG_GAIN_DERIV:     kd_q       = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            pending_count <= expected_steering.size();
        end
        mismatch_count <= errors;
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for line_follower_steering_pd
// Drives directed sensor samples, then phases of random samples under
// different register settings, with random gaps on the sample side and
// random stalls on the result side. A checker beside the block predicts and
// compares every result; this module gives the final verdict.
// ----------------------------------------------------------------------------
module testbench;
    import lfsp_pkg::*;

    localparam int SB              = 10;
    localparam int SAMPLE_MAX      = (1 << SB) - 1;
    localparam int RESET_CYCLES    = 11;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int QUIET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [ADDR_W-1:0]       paddr        = '0;
    logic [DATA_W-1:0]       pwdata       = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic [SB-1:0]           sensor_one   = '0;
    logic [SB-1:0]           sensor_two   = '0;
    logic [SB-1:0]           sensor_three = '0;
    logic [SB-1:0]           sensor_four  = '0;
    logic [SB-1:0]           sensor_five  = '0;
    logic [SB-1:0]           sensor_six   = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic signed [POS_W-1:0] line_position;
    logic                    mode_bang;
    logic [SPEED_W-1:0]      speed_a;
    logic [SPEED_W-1:0]      speed_b;
    logic                    speeds_valid;

    int mismatch_total;
    int pending_results;
    int idle_cycles = 0;

    // Stimulus state.
    logic [SB-1:0] next_sample [6];
    int            cur_threshold = LINE_THRESHOLD_RST;
    bit            no_idle = 1'b0;
    logic [31:0]   cfg_threshold;
    logic [31:0]   cfg_straight;
    logic [31:0]   cfg_slight;
    logic [31:0]   cfg_base;
    logic [31:0]   cfg_kp;
    logic [31:0]   cfg_kd;

    line_follower_steering_pd #(
        .SAMPLE_BITS(SB)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .sensor_one(sensor_one), .sensor_two(sensor_two), .sensor_three(sensor_three),
        .sensor_four(sensor_four), .sensor_five(sensor_five), .sensor_six(sensor_six),
        .out_valid(out_valid), .out_stall(out_stall),
        .line_position(line_position), .mode_bang(mode_bang),
        .speed_a(speed_a), .speed_b(speed_b), .speeds_valid(speeds_valid)
    );

    steering_checker #(
        .SAMPLE_BITS(SB)
    ) u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .sensor_one(sensor_one), .sensor_two(sensor_two), .sensor_three(sensor_three),
        .sensor_four(sensor_four), .sensor_five(sensor_five), .sensor_six(sensor_six),
        .out_valid(out_valid), .out_stall(out_stall),
        .line_position(line_position), .mode_bang(mode_bang),
        .speed_a(speed_a), .speed_b(speed_b), .speeds_valid(speeds_valid),
        .mismatch_count(mismatch_total), .pending_count(pending_results)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Seen patterns: the ten line positions, three with four, and none.
    function automatic logic [5:0] line_pattern(input int k);
        case (k)
            0:       return 6'b000001;
            1:       return 6'b000011;
            2:       return 6'b000010;
            3:       return 6'b000110;
            4:       return 6'b000100;
            5:       return 6'b001000;
            6:       return 6'b011000;
            7:       return 6'b010000;
            8:       return 6'b110000;
            9:       return 6'b100000;
            10:      return 6'b001100;
            default: return 6'b000000;
        endcase
    endfunction

    task automatic fill_exact(input logic [5:0] seen, input logic [SB-1:0] dark,
                              input logic [SB-1:0] bright);
        for (int i = 0; i < 6; i++)
            next_sample[i] = seen[i] ? dark : bright;
    endtask

    // Random readings on the proper side of the threshold, often right at it.
    task automatic fill_pattern(input logic [5:0] seen);
        for (int i = 0; i < 6; i++)
        begin
            if (seen[i] && cur_threshold != 0)
                next_sample[i] = ($urandom_range(0, 7) == 0) ? SB'(cur_threshold - 1)
                                 : SB'($urandom_range(0, cur_threshold - 1));
            else
                next_sample[i] = ($urandom_range(0, 7) == 0) ? SB'(cur_threshold)
                                 : SB'($urandom_range(cur_threshold, SAMPLE_MAX));
        end
    endtask

    task automatic random_sample();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            fill_pattern(line_pattern($urandom_range(0, 11)));
        else if (k < 85)
            fill_pattern(6'($urandom_range(0, 63)));
        else
            for (int i = 0; i < 6; i++)
                next_sample[i] = SB'($urandom_range(0, SAMPLE_MAX));
    endtask

    // One sample transfer, after an optional gap.
    task automatic send_sample();
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sensor_one   <= next_sample[0];
        sensor_two   <= next_sample[1];
        sensor_three <= next_sample[2];
        sensor_four  <= next_sample[3];
        sensor_five  <= next_sample[4];
        sensor_six   <= next_sample[5];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // Setup phase, access phase, then the port returns to idle.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Settings per phase: defaults, the extremes, then random words whose
    // upper bits lie beyond the register widths.
    task automatic choose_setting(input int phase);
        case (phase)
            0:
            begin
                cfg_threshold = LINE_THRESHOLD_RST;
                cfg_straight  = STRAIGHT_SPEED_RST;
                cfg_slight    = SLIGHT_SPEED_RST;
                cfg_base      = PD_BASE_SPEED_RST;
                cfg_kp        = GAIN_PROP_RST;
                cfg_kd        = GAIN_DERIV_RST;
            end
            1:
            begin
                cfg_threshold = '0;
                cfg_straight  = '0;
                cfg_slight    = '0;
                cfg_base      = '0;
                cfg_kp        = '0;
                cfg_kd        = '0;
            end
            2:
            begin
                cfg_threshold = '1;
                cfg_straight  = '1;
                cfg_slight    = '1;
                cfg_base      = '1;
                cfg_kp        = '1;
                cfg_kd        = '1;
            end
            3:
            begin
                cfg_threshold = 32'd1;
                cfg_straight  = 32'd255;
                cfg_slight    = 32'd0;
                cfg_base      = 32'd0;
                cfg_kp        = 32'd0;
                cfg_kd        = 32'd65535;
            end
            4:
            begin
                cfg_threshold = 32'd1023;
                cfg_straight  = 32'd0;
                cfg_slight    = 32'd255;
                cfg_base      = 32'd255;
                cfg_kp        = 32'd65535;
                cfg_kd        = 32'd0;
            end
            default:
            begin
                cfg_threshold = $urandom;
                cfg_straight  = $urandom;
                cfg_slight    = $urandom;
                cfg_base      = $urandom;
                cfg_kp        = $urandom;
                cfg_kd        = $urandom;
                // Keep the gains below 2048 in every random phase but phase 6.
                if (phase != 6)
                begin
                    cfg_kp[15:11] = '0;
                    cfg_kd[15:11] = '0;
                end
                if (phase == 7)
                    cfg_base[7:6] = 2'b01;
            end
        endcase
    endtask

    task automatic apply_setting();
        write_register(REG_LINE_THRESHOLD, cfg_threshold);
        write_register(REG_STRAIGHT_SPEED, cfg_straight);
        write_register(REG_SLIGHT_SPEED, cfg_slight);
        write_register(REG_PD_BASE_SPEED, cfg_base);
        write_register(REG_GAIN_PROP, cfg_kp);
        write_register(REG_GAIN_DERIV, cfg_kd);
        cur_threshold = int'(cfg_threshold[SB-1:0]);
    endtask

    // Result side: runs of ready cycles broken by random stalls.
    initial
    begin
        int run;
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            run = no_idle ? 16 : $urandom_range(1, 8);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            hold = idle_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Watchdog: cycles with no transfer on any port.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        logic [SB-1:0] at_thr;
        int            phase;
        int            n;
        at_thr = SB'(LINE_THRESHOLD_RST);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples under the reset settings.
        fill_exact(6'b000000, '0, '1);
        send_sample();
        fill_exact(6'b111111, '0, '1);
        send_sample();
        for (int k = 0; k < 12; k++)
        begin
            fill_exact(line_pattern(k), '0, '1);
            send_sample();
        end
        // Readings one below and exactly at the threshold.
        fill_exact(6'b000100, at_thr - 1'b1, at_thr);
        send_sample();
        fill_exact(6'b000000, at_thr - 1'b1, at_thr);
        send_sample();
        // Patterns with gaps or too wide a line decode to the center.
        fill_exact(6'b000101, '0, '1);
        send_sample();
        fill_exact(6'b100001, '0, '1);
        send_sample();
        fill_exact(6'b011110, '0, '1);
        send_sample();
        // A swing from far left to far right gives the largest derivative.
        fill_exact(6'b000001, '0, '1);
        send_sample();
        fill_exact(6'b100000, '0, '1);
        send_sample();
        fill_exact(6'b100000, '0, '1);
        send_sample();

        // Random phases, each under its own setting.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            hold_until_drained();
            repeat (QUIET_CYCLES) @(posedge clk);
            choose_setting(phase);
            apply_setting();
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                no_idle = (n >= 150 && n < 190);
                if (n == 100)
                    hold_until_drained();
                random_sample();
                send_sample();
            end
            no_idle = 1'b0;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && pending_results == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
